// File: rtl/core/sfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sfa_pkg;
    localparam int MAX_ANIMS_DEF  = 8;
    localparam int MAX_FRAMES_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    // input functions
    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_WRITE  = 3'd1;
    localparam logic [2:0] FUNC_DEFINE = 3'd2;
    localparam logic [2:0] FUNC_PLAY   = 3'd3;
    localparam logic [2:0] FUNC_STOP   = 3'd4;

    // register indexes
    localparam logic [1:0] REG_FRAME_W = 2'd0;
    localparam logic [1:0] REG_FRAME_H = 2'd1;
    localparam logic [1:0] REG_SHEET_W = 2'd2;
    localparam logic [1:0] REG_STEP    = 2'd3;

    localparam logic [23:0] Y_MAX = 24'hFFFFFF;

    // controller commands to datapath
    typedef struct packed {
        logic latch;      // capture input request
        logic eval;       // apply the request to playback state
        logic mem_rd;     // issue frame table read
        logic load_frame; // take frame from table read data
        logic div_init;   // start source division
        logic div_step;   // one quotient bit
        logic src_store;  // write x,y result
        logic src_zero;   // clear source registers
        logic done;       // present result
    } t_cmd;

    // datapath status to controller
    typedef struct packed {
        logic [2:0] func;
        logic       tick_live;  // tick while playing
        logic       tick_adv;   // tick moves to a new frame
        logic       tick_end;   // one-shot ended
        logic       play_live;  // play of a nonempty slot
    } t_stat;
endpackage
`default_nettype wire

// File: rtl/core/sfa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/sfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sfa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_div_last,
    input  wire sfa_pkg::t_stat i_stat,
    output logic               o_busy,
    output sfa_pkg::t_cmd      o_cmd
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_STORE = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                priority if (i_stat.func == sfa_pkg::FUNC_TICK && !i_stat.tick_live) begin
                    o_cmd.src_zero = 1'b1;
                    n_state        = ST_DONE;
                end else if (i_stat.func == sfa_pkg::FUNC_TICK && i_stat.tick_adv) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = ST_READ;
                end else if (i_stat.func == sfa_pkg::FUNC_TICK) begin
                    n_state = ST_LOAD;
                end else if (i_stat.func == sfa_pkg::FUNC_PLAY && i_stat.play_live) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = ST_READ;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_READ: begin
                o_cmd.load_frame = 1'b1;
                n_state = (i_stat.func == sfa_pkg::FUNC_TICK && i_stat.tick_end)
                        ? ST_DONE : ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.div_init = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_div_last) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                o_cmd.src_store = 1'b1;
                n_state         = ST_DONE;
            end
            ST_DONE: begin
                o_cmd.done = 1'b1;
                n_state    = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);
endmodule
`default_nettype wire

// File: rtl/core/sfa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module sfa_datapath #(
    parameter int MAX_ANIMS  = sfa_pkg::MAX_ANIMS_DEF,
    parameter int MAX_FRAMES = sfa_pkg::MAX_FRAMES_DEF,
    parameter int TIME_BITS  = sfa_pkg::TIME_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sfa_pkg::t_cmd i_cmd,
    output sfa_pkg::t_stat     o_stat,
    output logic               o_div_last,
    input  wire logic [2:0]    i_func,
    input  wire logic [2:0]    i_anim_slot,
    input  wire logic [3:0]    i_position,
    input  wire logic [7:0]    i_frame_number,
    input  wire logic [4:0]    i_anim_length,
    input  wire logic [31:0]   i_period,
    input  wire logic          i_looped,
    input  wire logic [11:0]   i_frame_width,
    input  wire logic [11:0]   i_frame_height,
    input  wire logic [11:0]   i_sheet_width,
    input  wire logic [31:0]   i_tick_step,
    output logic      [11:0]   o_source_x,
    output logic      [23:0]   o_source_y,
    output logic      [7:0]    o_shown_frame,
    output logic               o_finished,
    output logic               o_playing,
    output logic               o_done
);
    localparam int SW = (MAX_ANIMS > 1) ? $clog2(MAX_ANIMS) : 1;
    localparam int PW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int LW = $clog2(MAX_FRAMES + 1);
    localparam int AW = SW + PW;
    localparam int DEPTH = 1 << AW;
    localparam int TW = TIME_BITS;
    localparam int CW = (TW > 32) ? TW : 32;
    localparam int SUMW = CW + 1;
    localparam int RXW = 20;
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};

    // latched request
    logic [2:0]  r_func;
    logic [2:0]  r_slot;
    logic [4:0]  r_len;
    logic [31:0] r_per;
    logic        r_loop;

    logic [LW-1:0] r_slot_len [MAX_ANIMS];
    logic [31:0]   r_slot_per [MAX_ANIMS];
    logic          r_slot_loop [MAX_ANIMS];
    logic [SW-1:0] r_active;
    logic          r_playing;
    logic [4:0]    r_list_pos;
    logic [TW-1:0] r_accum;
    logic [7:0]    r_cur;
    logic [11:0]   r_src_x;
    logic [23:0]   r_src_y;
    logic          r_fin;
    logic          r_done;

    logic            slot_ok;
    logic [SW-1:0]   slot_i;
    logic [SW-1:0]   act_s;
    logic            act_ok;
    logic [SUMW-1:0] acc_sum;
    logic [TW-1:0]   acc_sat;
    logic            adv;
    logic [4:0]      pos_next;
    logic            wrap;
    logic [7:0]      rd_data;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic            wr_en;

    assign slot_ok = ({29'd0, r_slot} < MAX_ANIMS);
    assign slot_i  = SW'(r_slot);
    assign act_s   = r_active;
    assign act_ok  = 1'b1;

    // accumulator and advance test
    assign acc_sum  = SUMW'(r_accum) + SUMW'(i_tick_step);
    assign acc_sat  = (acc_sum > SUMW'(TMAX)) ? TMAX : acc_sum[TW-1:0];
    assign adv      = (CW'(acc_sat) >= CW'(r_slot_per[act_s]));
    assign pos_next = r_list_pos + 5'd1;
    assign wrap     = ({{(32-5){1'b0}}, pos_next} >= {{(32-LW){1'b0}}, r_slot_len[act_s]});

    assign o_stat.func      = r_func;
    assign o_stat.tick_live = r_playing && act_ok;
    assign o_stat.tick_adv  = adv;
    assign o_stat.tick_end  = r_fin;
    assign o_stat.play_live = slot_ok && (r_slot_len[slot_i] != '0);

    // frame table
    assign wr_en   = i_cmd.latch && i_func == sfa_pkg::FUNC_WRITE
                     && ({29'd0, i_anim_slot} < MAX_ANIMS)
                     && ({28'd0, i_position} < MAX_FRAMES);
    assign wr_addr = {SW'(i_anim_slot), PW'(i_position)};
    assign rd_addr = (r_func == sfa_pkg::FUNC_PLAY) ? {slot_i, {PW{1'b0}}}
                   : (wrap ? {act_s, {PW{1'b0}}} : {act_s, PW'(pos_next)});

    sfa_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_table (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_addr),
        .i_wdata(i_frame_number),
        .i_re   (i_cmd.mem_rd),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    // restoring divider for rx / sheet_width, one quotient bit a cycle
    logic [RXW-1:0] r_num;
    logic [11:0]    r_rem;
    logic [RXW-1:0] r_quo;
    logic [4:0]     r_cnt;
    logic [12:0]    trial;
    logic [11:0]    rem_sh_lo;
    logic [31:0]    y_full;

    assign trial      = {r_rem, r_num[RXW-1]} - {1'b0, i_sheet_width};
    assign rem_sh_lo  = trial[12] ? {r_rem[10:0], r_num[RXW-1]} : trial[11:0];
    assign o_div_last = (r_cnt == 5'(RXW - 1));
    assign y_full     = 32'(r_quo) * 32'(i_frame_height);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_num <= RXW'(r_cur) * RXW'(i_frame_width);
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_sh_lo;
            r_num <= {r_num[RXW-2:0], 1'b0};
            r_quo <= {r_quo[RXW-2:0], ~trial[12]};
            r_cnt <= r_cnt + 5'd1;
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ANIMS; i++) begin
                r_slot_len[i]  <= '0;
                r_slot_per[i]  <= '0;
                r_slot_loop[i] <= 1'b0;
            end
            r_active   <= '0;
            r_playing  <= 1'b0;
            r_list_pos <= '0;
            r_accum    <= '0;
            r_cur      <= '0;
            r_src_x    <= '0;
            r_src_y    <= '0;
            r_fin      <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= i_cmd.done;
            if (i_cmd.latch) begin
                r_func <= i_func;
                r_slot <= i_anim_slot;
                r_len  <= i_anim_length;
                r_per  <= i_period;
                r_loop <= i_looped;
                if (i_func == sfa_pkg::FUNC_TICK) begin
                    r_fin <= 1'b0;
                end
                if (i_func == sfa_pkg::FUNC_STOP) begin
                    r_playing <= 1'b0;
                    r_accum   <= '0;
                end
            end
            // per-request update in the eval cycle
            if (i_cmd.eval) begin
                if (r_func == sfa_pkg::FUNC_TICK && o_stat.tick_live) begin
                    if (adv) begin
                        r_accum    <= '0;
                        r_list_pos <= wrap ? 5'd0 : pos_next;
                        if (wrap && !r_slot_loop[act_s]) begin
                            r_playing <= 1'b0;
                            r_fin     <= 1'b1;
                        end
                    end else begin
                        r_accum <= acc_sat;
                    end
                end
                if (r_func == sfa_pkg::FUNC_DEFINE && slot_ok) begin
                    r_slot_len[slot_i]  <= (32'(r_len) > MAX_FRAMES) ? LW'(MAX_FRAMES)
                                         : LW'(r_len);
                    r_slot_per[slot_i]  <= r_per;
                    r_slot_loop[slot_i] <= r_loop;
                end
                // play of an empty slot acts as stop
                if (r_func == sfa_pkg::FUNC_PLAY && slot_ok) begin
                    if (o_stat.play_live) begin
                        r_active   <= slot_i;
                        r_playing  <= 1'b1;
                        r_list_pos <= '0;
                        r_accum    <= '0;
                    end else begin
                        r_playing <= 1'b0;
                        r_accum   <= '0;
                    end
                end
            end
            if (i_cmd.src_zero) begin
                r_src_x <= '0;
                r_src_y <= '0;
            end
            if (i_cmd.load_frame) begin
                r_cur <= rd_data;
            end
            if (i_cmd.src_store) begin
                if (i_sheet_width == '0) begin
                    r_src_x <= '0;
                    r_src_y <= '0;
                end else begin
                    r_src_x <= r_rem;
                    r_src_y <= (y_full > {8'd0, sfa_pkg::Y_MAX}) ? sfa_pkg::Y_MAX
                             : y_full[23:0];
                end
            end
        end
    end

    assign o_source_x    = r_src_x;
    assign o_source_y    = r_src_y;
    assign o_shown_frame = r_cur;
    assign o_finished    = (r_func == sfa_pkg::FUNC_TICK) && r_fin;
    assign o_playing     = r_playing;
    assign o_done        = r_done;
endmodule
`default_nettype wire

// File: rtl/core/sprite_frame_animator.sv
`timescale 1ns / 1ps
`default_nettype none
// sprite sheet frame animator
// requests enter on start while busy is low; fields i_func, i_anim_slot,
// i_position, i_frame_number, i_anim_length, i_period, i_looped are sampled
// at that edge. every request gives one result on o_source_x, o_source_y,
// o_shown_frame, o_finished, o_playing, marked by o_valid for one cycle.
// a tick that moves to a new frame or a play of a nonempty slot passes
// eval, frame table read, load, the bit-serial divide of frame offset by
// sheet width, store and done; a tick that stays on its frame skips the
// read, a tick that ends a one-shot goes from read to done, any other
// request from eval to done. busy drops as o_valid rises, so the next
// request can be taken at the edge that takes the result: one request in flight.
// the receiver cannot stall: the result is there for exactly one cycle.
// registers on the apb port: 0 frame width, 1 frame height, 2 sheet width,
// 3 tick step (16.16); write them only while busy is low.
// reset (synchronous, active low) clears slot settings, playback state,
// source registers and registers to their defaults; frame table contents
// are undefined until written.
module sprite_frame_animator #(
    parameter int MAX_ANIMS  = sfa_pkg::MAX_ANIMS_DEF,
    parameter int MAX_FRAMES = sfa_pkg::MAX_FRAMES_DEF,
    parameter int TIME_BITS  = sfa_pkg::TIME_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_func,
    input  wire logic [2:0]  i_anim_slot,
    input  wire logic [3:0]  i_position,
    input  wire logic [7:0]  i_frame_number,
    input  wire logic [4:0]  i_anim_length,
    input  wire logic [31:0] i_period,
    input  wire logic        i_looped,
    output logic             o_valid,
    output logic      [11:0] o_source_x,
    output logic      [23:0] o_source_y,
    output logic      [7:0]  o_shown_frame,
    output logic             o_finished,
    output logic             o_playing,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    logic [11:0] r_frame_w;
    logic [11:0] r_frame_h;
    logic [11:0] r_sheet_w;
    logic [31:0] r_step;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= 12'd16;
            r_frame_h <= 12'd16;
            r_sheet_w <= 12'd256;
            r_step    <= 32'd1092;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                sfa_pkg::REG_FRAME_W: r_frame_w <= pwdata[11:0];
                sfa_pkg::REG_FRAME_H: r_frame_h <= pwdata[11:0];
                sfa_pkg::REG_SHEET_W: r_sheet_w <= pwdata[11:0];
                sfa_pkg::REG_STEP:    r_step    <= pwdata;
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        unique case (paddr[3:2])
            sfa_pkg::REG_FRAME_W: prdata = {20'd0, r_frame_w};
            sfa_pkg::REG_FRAME_H: prdata = {20'd0, r_frame_h};
            sfa_pkg::REG_SHEET_W: prdata = {20'd0, r_sheet_w};
            sfa_pkg::REG_STEP:    prdata = r_step;
            default:              prdata = '0;
        endcase
    end

    sfa_pkg::t_cmd  cmd;
    sfa_pkg::t_stat stat;
    logic           div_last;

    sfa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_div_last(div_last),
        .i_stat    (stat),
        .o_busy    (busy),
        .o_cmd     (cmd)
    );

    sfa_datapath #(
        .MAX_ANIMS (MAX_ANIMS),
        .MAX_FRAMES(MAX_FRAMES),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_div_last    (div_last),
        .i_func        (i_func),
        .i_anim_slot   (i_anim_slot),
        .i_position    (i_position),
        .i_frame_number(i_frame_number),
        .i_anim_length (i_anim_length),
        .i_period      (i_period),
        .i_looped      (i_looped),
        .i_frame_width (r_frame_w),
        .i_frame_height(r_frame_h),
        .i_sheet_width (r_sheet_w),
        .i_tick_step   (r_step),
        .o_source_x    (o_source_x),
        .o_source_y    (o_source_y),
        .o_shown_frame (o_shown_frame),
        .o_finished    (o_finished),
        .o_playing     (o_playing),
        .o_done        (o_valid)
    );
endmodule
`default_nettype wire

// File: rtl/core/sfa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sfa_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid,
    input wire logic o_finished,
    input wire logic o_playing,
    input wire logic pready
);
    // accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accept without busy");

    // result never while busy
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");

    // a finished one-shot is no longer playing
    a_fin_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_finished |-> !o_playing) else $error("finished yet playing");

    // apb never waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready) else $error("pready low");
endmodule

bind sprite_frame_animator sfa_checker u_sfa_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_valid   (o_valid),
    .o_finished(o_finished),
    .o_playing (o_playing),
    .pready    (pready)
);
`default_nettype wire

// File: tb/sprite_frame_animator_tb.sv
`timescale 1ns / 1ps
module sprite_frame_animator_tb;

    localparam int SLOTS  = 8;
    localparam int FRAMES = 16;

    typedef struct packed {
        logic [2:0]  func;
        logic [2:0]  slot;
        logic [3:0]  pos;
        logic [7:0]  fnum;
        logic [4:0]  len;
        logic [31:0] per;
        logic        loop;
    } t_anim_req;

    typedef struct packed {
        logic [11:0] x;
        logic [23:0] y;
        logic [7:0]  frame;
        logic        fin;
        logic        play;
    } t_anim_res;

    typedef struct packed {
        t_anim_req req;
        logic      chk;
        t_anim_res res;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_func;
    logic [2:0]  i_anim_slot;
    logic [3:0]  i_position;
    logic [7:0]  i_frame_number;
    logic [4:0]  i_anim_length;
    logic [31:0] i_period;
    logic        i_looped;
    logic        o_valid;
    logic [11:0] o_source_x;
    logic [23:0] o_source_y;
    logic [7:0]  o_shown_frame;
    logic        o_finished;
    logic        o_playing;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sprite_frame_animator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_anim_slot(i_anim_slot), .i_position(i_position),
        .i_frame_number(i_frame_number), .i_anim_length(i_anim_length),
        .i_period(i_period), .i_looped(i_looped), .o_valid(o_valid),
        .o_source_x(o_source_x), .o_source_y(o_source_y),
        .o_shown_frame(o_shown_frame), .o_finished(o_finished),
        .o_playing(o_playing), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // animator model state
    logic [7:0]  m_table [SLOTS*FRAMES];
    logic        m_written [SLOTS*FRAMES];
    logic [4:0]  m_len [SLOTS];
    logic [31:0] m_per [SLOTS];
    logic        m_loop [SLOTS];
    logic [2:0]  m_active;
    logic        m_playing;
    logic [4:0]  m_lpos;
    logic [31:0] m_accum;
    logic [7:0]  m_frame;
    logic [11:0] m_x;
    logic [23:0] m_y;
    logic        m_fin;
    logic [11:0] cfg_fw, cfg_fh, cfg_sw;
    logic [31:0] cfg_step;

    t_anim_res expected_frames [$];
    t_anim_res typed_res [$];
    logic      typed_chk [$];
    int        errors;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // sheet position of the current frame
    function automatic void place_frame();
        logic [63:0] rx, ry;
        rx = 64'(m_frame) * 64'(cfg_fw);
        ry = 0;
        if (cfg_sw == 0) begin
            m_x = 0;
            m_y = 0;
            return;
        end
        if (rx >= 64'(cfg_sw)) begin
            ry = (rx / 64'(cfg_sw)) * 64'(cfg_fh);
            rx = rx % 64'(cfg_sw);
        end
        m_x = rx[11:0];
        m_y = (ry > 64'(sfa_pkg::Y_MAX)) ? sfa_pkg::Y_MAX : ry[23:0];
    endfunction

    // apply one request to the model, return the shown state
    function automatic t_anim_res animate(input t_anim_req r);
        t_anim_res   o;
        logic [32:0] sum;
        int          s;
        s = r.slot;
        case (r.func)
            sfa_pkg::FUNC_TICK: begin
                m_fin = 1'b0;
                if (!m_playing) begin
                    m_x = 0;
                    m_y = 0;
                end else begin
                    sum = 33'(m_accum) + 33'(cfg_step);
                    m_accum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    if (m_accum >= m_per[m_active]) begin
                        m_accum = 0;
                        m_lpos = m_lpos + 5'd1;
                        if (m_lpos >= m_len[m_active]) begin
                            m_lpos = 0;
                            m_frame = m_table[m_active*FRAMES];
                            if (!m_loop[m_active]) begin
                                m_playing = 1'b0;
                                m_fin = 1'b1;
                            end else begin
                                place_frame();
                            end
                        end else begin
                            m_frame = m_table[m_active*FRAMES + m_lpos];
                            place_frame();
                        end
                    end else begin
                        place_frame();
                    end
                end
            end
            sfa_pkg::FUNC_WRITE: begin
                m_table[s*FRAMES + r.pos] = r.fnum;
                m_written[s*FRAMES + r.pos] = 1'b1;
            end
            sfa_pkg::FUNC_DEFINE: begin
                m_len[s] = (r.len > 5'd16) ? 5'd16 : r.len;
                m_per[s] = r.per;
                m_loop[s] = r.loop;
            end
            sfa_pkg::FUNC_PLAY: begin
                if (m_len[s] == 0) begin
                    m_playing = 1'b0;
                    m_accum = 0;
                end else begin
                    m_active = r.slot;
                    m_playing = 1'b1;
                    m_lpos = 0;
                    m_accum = 0;
                    m_frame = m_table[s*FRAMES];
                    place_frame();
                end
            end
            sfa_pkg::FUNC_STOP: begin
                m_playing = 1'b0;
                m_accum = 0;
            end
            default: ;
        endcase
        o.x = m_x;
        o.y = m_y;
        o.frame = m_frame;
        o.fin = (r.func == sfa_pkg::FUNC_TICK) && m_fin;
        o.play = m_playing;
        return o;
    endfunction

    // a define whose frame list is not yet filled becomes a write of the gap
    function automatic t_anim_req fill_gap(input t_anim_req r);
        int need;
        if (r.func != sfa_pkg::FUNC_DEFINE) return r;
        need = (r.len > 5'd16) ? 16 : int'(r.len);
        if (need == 0) need = 1;
        for (int p = 0; p < need; p++) begin
            if (!m_written[r.slot*FRAMES + p]) begin
                r.func = sfa_pkg::FUNC_WRITE;
                r.pos = p[3:0];
                return r;
            end
        end
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_anim_res e;
        logic      c;
        if (i_rst_n && o_valid) begin
            if (expected_frames.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                e = expected_frames.pop_front();
                c = typed_chk.pop_front();
                if (c) begin
                    e = typed_res.pop_front();
                end
                if (o_source_x != e.x) report_mismatch("source_x", o_source_x, e.x);
                if (o_source_y != e.y) report_mismatch("source_y", o_source_y, e.y);
                if (o_shown_frame != e.frame)
                    report_mismatch("shown_frame", o_shown_frame, e.frame);
                if (o_finished != e.fin) report_mismatch("finished", o_finished, e.fin);
                if (o_playing != e.play) report_mismatch("playing", o_playing, e.play);
            end
        end
    end

    // issue one request and hold it until accepted
    task automatic send_request(input t_anim_req r, input logic chk, input t_anim_res typed);
        t_anim_res p;
        logic      keep;
        r = fill_gap(r);
        start          <= 1'b1;
        i_func         <= r.func;
        i_anim_slot    <= r.slot;
        i_position     <= r.pos;
        i_frame_number <= r.fnum;
        i_anim_length  <= r.len;
        i_period       <= r.per;
        i_looped       <= r.loop;
        do @(posedge i_clk); while (busy);
        p = animate(r);
        // a typed row is only kept if the request, as sent, is not a write
        keep = chk && r.func != sfa_pkg::FUNC_WRITE;
        expected_frames = {expected_frames, p};
        typed_chk = {typed_chk, keep};
        if (keep) typed_res = {typed_res, typed};
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            sfa_pkg::REG_FRAME_W: cfg_fw = val[11:0];
            sfa_pkg::REG_FRAME_H: cfg_fh = val[11:0];
            sfa_pkg::REG_SHEET_W: cfg_sw = val[11:0];
            default:              cfg_step = val;
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_anim_req random_request();
        t_anim_req   r;
        logic [63:0] bits;
        int          pick;
        bits = {$urandom, $urandom};
        r = bits[55:0];
        pick = $urandom_range(0, 99);
        if (pick < 45)      r.func = sfa_pkg::FUNC_TICK;
        else if (pick < 65) r.func = sfa_pkg::FUNC_WRITE;
        else if (pick < 77) r.func = sfa_pkg::FUNC_DEFINE;
        else if (pick < 89) r.func = sfa_pkg::FUNC_PLAY;
        else if (pick < 94) r.func = sfa_pkg::FUNC_STOP;
        else                r.func = 3'($urandom_range(5, 7));
        // short lists and periods near the step so frames actually move
        if ($urandom_range(0, 3) != 0) r.len = 5'($urandom_range(0, 6));
        case ($urandom_range(0, 4))
            0:       r.per = 0;
            1, 2:    r.per = cfg_step * $urandom_range(1, 3);
            3:       r.per = cfg_step * $urandom_range(1, 3) - $urandom_range(0, 2);
            default: ;
        endcase
        return r;
    endfunction

    t_dir_row directed [$];

    function automatic t_dir_row row(input logic [2:0] f, input logic [2:0] s,
                                     input logic [3:0] p, input logic [7:0] n,
                                     input logic [4:0] l, input logic [31:0] per,
                                     input logic lp, input logic chk,
                                     input t_anim_res res);
        t_dir_row d;
        d.req = '{f, s, p, n, l, per, lp};
        d.chk = chk;
        d.res = res;
        return d;
    endfunction

    task automatic add_row(input t_dir_row d);
        directed = {directed, d};
    endtask

    initial begin
        t_anim_res z;
        int        gap_pct;
        errors = 0;
        z = '0;
        start = 0; i_func = 0; i_anim_slot = 0; i_position = 0; i_frame_number = 0;
        i_anim_length = 0; i_period = 0; i_looped = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        for (int i = 0; i < SLOTS*FRAMES; i++) begin
            m_table[i] = 0;
            m_written[i] = 0;
        end
        for (int i = 0; i < SLOTS; i++) begin
            m_len[i] = 0; m_per[i] = 0; m_loop[i] = 0;
        end
        m_active = 0; m_playing = 0; m_lpos = 0; m_accum = 0; m_frame = 0;
        m_x = 0; m_y = 0; m_fin = 0;
        cfg_fw = 16; cfg_fh = 16; cfg_sw = 256; cfg_step = 1092;

        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        add_row(row(sfa_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 1, z));
        add_row(row(sfa_pkg::FUNC_STOP, 0, 0, 0, 0, 0, 0, 1, z));
        add_row(row(3'd5, 0, 0, 0, 0, 0, 0, 1, z));
        add_row(row(sfa_pkg::FUNC_WRITE, 0, 0, 8'hFF, 0, 0, 0, 1, z));
        add_row(row(sfa_pkg::FUNC_WRITE, 0, 1, 8'h00, 0, 0, 0, 1, z));
        add_row(row(sfa_pkg::FUNC_WRITE, 0, 15, 8'hAA, 0, 0, 0, 1, z));
        add_row(row(sfa_pkg::FUNC_WRITE, 7, 8, 8'h55, 0, 0, 0, 1, z));
        add_row(row(sfa_pkg::FUNC_DEFINE, 0, 0, 0, 2, 0, 0, 1, z));
        add_row(row(sfa_pkg::FUNC_PLAY, 0, 0, 0, 0, 0, 0, 1,
                    '{12'd240, 24'd240, 8'hFF, 1'b0, 1'b1}));
        add_row(row(sfa_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 1,
                    '{12'd0, 24'd0, 8'h00, 1'b0, 1'b1}));
        add_row(row(sfa_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 1,
                    '{12'd0, 24'd0, 8'hFF, 1'b1, 1'b0}));
        add_row(row(sfa_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 1,
                    '{12'd0, 24'd0, 8'hFF, 1'b0, 1'b0}));
        add_row(row(sfa_pkg::FUNC_WRITE, 1, 0, 8'h07, 0, 0, 0, 0, z));
        add_row(row(sfa_pkg::FUNC_DEFINE, 1, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, z));
        add_row(row(sfa_pkg::FUNC_PLAY, 1, 0, 0, 0, 0, 0, 1,
                    '{12'd0, 24'd0, 8'hFF, 1'b0, 1'b0}));
        add_row(row(sfa_pkg::FUNC_DEFINE, 0, 0, 0, 31, 32'hFFFF_FFFF, 1, 0, z));
        add_row(row(3'd7, 0, 0, 0, 0, 0, 0, 0, z));
        add_row(row(3'd6, 0, 0, 0, 0, 0, 0, 0, z));
        add_row(row(sfa_pkg::FUNC_DEFINE, 0, 0, 0, 2, 32'd3000, 1, 0, z));
        add_row(row(sfa_pkg::FUNC_PLAY, 0, 0, 0, 0, 0, 0, 0, z));
        add_row(row(sfa_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, z));
        add_row(row(sfa_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, z));
        add_row(row(sfa_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, z));
        add_row(row(sfa_pkg::FUNC_STOP, 0, 0, 0, 0, 0, 0, 0, z));
        add_row(row(sfa_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, z));
        foreach (directed[i]) send_request(directed[i].req, directed[i].chk, directed[i].res);
        drain();

        // random phases, each under its own register setting
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(sfa_pkg::REG_FRAME_W, 4095);
                    write_reg(sfa_pkg::REG_FRAME_H, 4095);
                    write_reg(sfa_pkg::REG_SHEET_W, 1);
                    write_reg(sfa_pkg::REG_STEP, 32'hFFFF_FFFF);
                end
                1: begin
                    write_reg(sfa_pkg::REG_FRAME_W, 1);
                    write_reg(sfa_pkg::REG_FRAME_H, 1);
                    write_reg(sfa_pkg::REG_SHEET_W, 4095);
                    write_reg(sfa_pkg::REG_STEP, 0);
                end
                2: begin
                    write_reg(sfa_pkg::REG_FRAME_W, 16);
                    write_reg(sfa_pkg::REG_FRAME_H, 16);
                    write_reg(sfa_pkg::REG_SHEET_W, 256);
                    write_reg(sfa_pkg::REG_STEP, 1092);
                end
                default: begin
                    write_reg(sfa_pkg::REG_FRAME_W, $urandom_range(1, 4095));
                    write_reg(sfa_pkg::REG_FRAME_H, $urandom_range(1, 4095));
                    write_reg(sfa_pkg::REG_SHEET_W, $urandom_range(1, 4095));
                    write_reg(sfa_pkg::REG_STEP, $urandom);
                end
            endcase
            gap_pct = (ph < 2) ? 21 : (ph < 4) ? 63 : 0;
            for (int n = 0; n < 100; n++) begin
                send_request(random_request(), 1'b0, z);
                if (n == 50 && ph == 3) begin
                    // hold off until the pipe is empty
                    start <= 1'b0;
                    while (expected_frames.size() != 0) @(posedge i_clk);
                end else if ($urandom_range(0, 99) < gap_pct) begin
                    idle_gap($urandom_range(1, 30));
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/sfa_pkg.sv
rtl/core/sfa_ram.sv
rtl/core/sfa_ctrl.sv
rtl/core/sfa_datapath.sv
rtl/core/sprite_frame_animator.sv
rtl/core/sfa_checker.sv
tb/sprite_frame_animator_tb.sv
